>>> rtl/bia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types and constants of the bitmap identifier allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

  // bitmap word geometry
  localparam int WORD_W  = 64;
  localparam int WORD_SB = 6;

  // field widths
  localparam int ID_W    = 16;
  localparam int GRANT_W = 17;
  localparam int CNT_W   = 14;
  localparam int N_W     = 17;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register reset values
  localparam logic [ID_W-1:0]  BASE_RESET  = 16'd300;
  localparam logic [CNT_W-1:0] COUNT_RESET = 14'd4701;

  // register indexes
  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // request codes
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_NOT_USED  = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    clr_wr;
    logic    load;
    logic    scan_rd;
    logic    rel_rd;
    logic    alloc_wr;
    logic    rel_wr;
    logic    res_set;
    status_t res_code;
    logic    push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic alloc_op;
    logic in_range;
    logic n_zero;
    logic found;
    logic exhausted;
    logic bit_set;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/bia_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_ctrl
// Sequencer: clearing pass, request decode, bitmap scan and result hand-off.
// ----------------------------------------------------------------------------
module bia_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bia_pkg::sts_t sts,
  output bia_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_START = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_RCHK  = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_code = bia_pkg::ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.alloc_op) begin
          if (sts.n_zero) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = bia_pkg::ST_NONE_FREE;
            state_next   = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end else if (!sts.in_range) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = bia_pkg::ST_RANGE;
          state_next   = S_DONE;
        end else begin
          cmd.rel_rd = 1'b1;
          state_next = S_RCHK;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.found) begin
          cmd.alloc_wr = 1'b1;
          state_next   = S_DONE;
        end else if (sts.exhausted) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = bia_pkg::ST_NONE_FREE;
          state_next   = S_DONE;
        end
      end
      S_RCHK: begin
        if (sts.bit_set) begin
          cmd.rel_wr = 1'b1;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_code = bia_pkg::ST_NOT_USED;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // no request taken while the bitmap is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("request accepted during clearing pass");

  // a load always leads to decode on the next cycle
  a_load_then_start: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_START))
    else $error("load not followed by decode");

  // the scan never runs for an empty range
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !sts.n_zero)
    else $error("scan with zero slot count");

endmodule
`default_nettype wire

>>> rtl/bia_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bia_dpath
// Bitmap memory, word pointer, first-free search, range check and result
// registers.
// ----------------------------------------------------------------------------
module bia_dpath #(
  parameter int SLOT_LIMIT = 8192
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bia_pkg::cmd_t                 cmd,
  output bia_pkg::sts_t                      sts,
  input  wire logic [bia_pkg::ID_W-1:0]      base_id,
  input  wire logic [bia_pkg::N_W-1:0]       n_act,
  input  wire logic                          operation,
  input  wire logic [bia_pkg::ID_W-1:0]      id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [bia_pkg::GRANT_W-1:0]        granted_id
);

  localparam int WW    = bia_pkg::WORD_W;
  localparam int WSB   = bia_pkg::WORD_SB;
  localparam int WORDS = (SLOT_LIMIT + WW - 1) / WW;
  localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SB    = WA + WSB;

  logic [WW-1:0] mem [WORDS];
  logic [WW-1:0] rd_data;

  logic [WA-1:0]  ptr;
  logic [WA-1:0]  chk_ptr;
  logic           chk_vld;
  logic           scan_more;
  logic [WSB-1:0] bitsel;
  logic           op_q;
  logic           in_range_q;

  bia_pkg::status_t           res_status;
  logic [bia_pkg::GRANT_W-1:0] res_granted;

  // range check on the incoming identifier
  logic [bia_pkg::N_W-1:0] diff;
  logic                    in_range;
  assign diff     = {1'b0, id} - {1'b0, base_id};
  assign in_range = !diff[bia_pkg::N_W-1] && (diff < n_act);

  // last word of the active range and its tail mask
  logic [bia_pkg::N_W-1:0] nm1;
  logic [WA-1:0]           last_word;
  logic [WW-1:0]           tail_mask;
  logic [WW-1:0]           word_mask;
  assign nm1       = n_act - bia_pkg::N_W'(1);
  assign last_word = nm1[SB-1:WSB];
  assign tail_mask = {WW{1'b1}} >> (WSB'(WW - 1) - nm1[WSB-1:0]);
  assign word_mask = (chk_ptr == last_word) ? tail_mask : {WW{1'b1}};

  // lowest free bit of the checked word
  logic [WW-1:0]  free_bits;
  logic [WSB-1:0] pick;
  assign free_bits = ~rd_data & word_mask;
  always_comb begin
    pick = '0;
    for (int b = WW - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        pick = WSB'(b);
      end
    end
  end

  logic                          found;
  logic [bia_pkg::GRANT_W-1:0]   grant_sum;
  assign found     = chk_vld && (|free_bits);
  assign grant_sum = bia_pkg::GRANT_W'(base_id) + bia_pkg::GRANT_W'({chk_ptr, pick});

  // read and write controls
  logic          rd_en;
  logic          scan_issue;
  logic          wr_en;
  logic [WA-1:0] wr_addr;
  logic [WW-1:0] wr_data;
  assign scan_issue = cmd.scan_rd && scan_more;
  assign rd_en      = scan_issue || cmd.rel_rd;
  assign wr_en      = cmd.clr_wr || cmd.alloc_wr || cmd.rel_wr;
  assign wr_addr    = cmd.clr_wr ? ptr : chk_ptr;
  always_comb begin
    if (cmd.clr_wr) begin
      wr_data = '0;
    end else if (cmd.alloc_wr) begin
      wr_data = rd_data | (WW'(1) << pick);
    end else begin
      wr_data = rd_data & ~(WW'(1) << bitsel);
    end
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[ptr];
    end
  end

  // word pointer and scan tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      chk_vld   <= 1'b0;
      scan_more <= 1'b0;
    end else if (cmd.load) begin
      ptr       <= (operation == bia_pkg::OP_ALLOC) ? '0 : diff[SB-1:WSB];
      chk_vld   <= 1'b0;
      scan_more <= 1'b1;
    end else begin
      chk_vld <= rd_en;
      if (cmd.clr_wr || scan_issue) begin
        ptr <= ptr + WA'(1);
      end
      if (scan_issue && (ptr == last_word)) begin
        scan_more <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_ptr <= ptr;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= operation;
      in_range_q <= in_range;
      bitsel     <= diff[WSB-1:0];
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.alloc_wr) begin
      res_status  <= bia_pkg::ST_OK;
      res_granted <= grant_sum;
    end else if (cmd.rel_wr) begin
      res_status  <= bia_pkg::ST_OK;
      res_granted <= '0;
    end else if (cmd.res_set) begin
      res_status  <= cmd.res_code;
      res_granted <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      status     <= res_status;
      granted_id <= res_granted;
    end
  end

  // status to the controller
  always_comb begin
    sts           = '0;
    sts.clr_last  = (ptr == WA'(WORDS - 1));
    sts.alloc_op  = (op_q == bia_pkg::OP_ALLOC);
    sts.in_range  = in_range_q;
    sts.n_zero    = (n_act == '0);
    sts.found     = found;
    sts.exhausted = chk_vld && (chk_ptr == last_word) && !found;
    sts.bit_set   = rd_data[bitsel];
    sts.out_busy  = out_valid && !out_ready;
  end

  // an allocate write only lands on a word holding a free bit
  a_alloc_on_found: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_wr |-> found)
    else $error("allocate write without a free bit");

  // a release write only clears a bit that was set
  a_rel_on_set: assert property (@(posedge clk) disable iff (rst)
    cmd.rel_wr |-> (chk_vld && rd_data[bitsel]))
    else $error("release write of an unused slot");

  // one writer per cycle
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_wr, cmd.alloc_wr, cmd.rel_wr}))
    else $error("conflicting bitmap writes");

  // a failed result carries no identifier; a release result is zeroed as well
  a_zero_grant: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && (res_status != bia_pkg::ST_OK)) |=> (granted_id == '0))
    else $error("identifier reported on a failed request");

endmodule
`default_nettype wire

>>> rtl/bitmap_id_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_id_allocator_core
// Identifier allocator keeping one in-use bit per identifier.
// ----------------------------------------------------------------------------
// Usage
//   Request words (operation, id) enter on in_valid/in_ready; operation 0
//   allocates the lowest free identifier, 1 releases id. Each request gives
//   one result word (status, granted_id) on out_valid/out_ready.
//   base_id (address 0) and slot_count (address 4) are written over the APB
//   port while no request is in flight; pready is always high.
// Operation
//   The bitmap is a memory of 64-bit words. An allocate streams one word
//   per cycle through the first-free search, starting at word 0. A release
//   reads and rewrites one word; an out-of-range release or an allocate on
//   an empty pool gives its result without a bitmap access. One request is
//   processed at a time.
// Reset and stall
//   After reset a clearing pass zeroes one word per cycle, all SLOT_LIMIT/64
//   words (rounded up), with in_ready low; APB writes are taken as ever.
//   A result waits in the output register while the receiver stalls; the
//   next request is accepted and worked on meanwhile, and its result waits
//   until the output register is free.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_core #(
  parameter int SLOT_LIMIT = 8192
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bia_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [bia_pkg::PDATA_W-1:0]   pwdata,
  output logic [bia_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          operation,
  input  wire logic [bia_pkg::ID_W-1:0]      id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [bia_pkg::GRANT_W-1:0]        granted_id
);

  logic [bia_pkg::ID_W-1:0]  base_id;
  logic [bia_pkg::CNT_W-1:0] slot_count;
  logic [bia_pkg::N_W-1:0]   n_act;
  logic                      reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_id    <= bia_pkg::BASE_RESET;
      slot_count <= bia_pkg::COUNT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        bia_pkg::REG_BASE:  base_id    <= pwdata[bia_pkg::ID_W-1:0];
        bia_pkg::REG_COUNT: slot_count <= pwdata[bia_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      bia_pkg::REG_BASE:  prdata = bia_pkg::PDATA_W'(base_id);
      bia_pkg::REG_COUNT: prdata = bia_pkg::PDATA_W'(slot_count);
      default:            prdata = '0;
    endcase
  end

  // active slot count, capped at the bitmap size
  assign n_act = (bia_pkg::N_W'(slot_count) > bia_pkg::N_W'(SLOT_LIMIT)) ?
                 bia_pkg::N_W'(SLOT_LIMIT) : bia_pkg::N_W'(slot_count);

  bia_pkg::cmd_t cmd;
  bia_pkg::sts_t sts;

  bia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bia_dpath #(
    .SLOT_LIMIT (SLOT_LIMIT)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .base_id    (base_id),
    .n_act      (n_act),
    .operation  (operation),
    .id         (id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .granted_id (granted_id)
  );

endmodule
`default_nettype wire

>>> tb/tb_bitmap_id_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_id_allocator_core
// Self-checking bench for the bitmap identifier allocator. A scoreboard keeps
// its own in-use bitmap and register copies, works out the status and granted
// identifier of every accepted request word and compares each result word in
// order. A directed opening covers range edges, empty and full pools, capped
// and zero slot counts and the top base; random phases follow, with random
// settings, idling on both sides and two long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_bitmap_id_allocator_core;

  localparam int SLOT_LIMIT  = 8192;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 165;

  typedef struct packed {
    bia_pkg::status_t             st;
    logic [bia_pkg::GRANT_W-1:0]  gid;
  } alloc_result_t;

  // predicts allocator results and holds them until they come out
  class alloc_scoreboard;
    bit                           in_use [SLOT_LIMIT];
    logic [bia_pkg::ID_W-1:0]     base;
    logic [bia_pkg::CNT_W-1:0]    count;
    alloc_result_t                pending_results [$];
    int                           errors;

    function new();
      base   = bia_pkg::BASE_RESET;
      count  = bia_pkg::COUNT_RESET;
      errors = 0;
      foreach (in_use[i]) in_use[i] = 1'b0;
    endfunction

    function int active_slots();
      return (int'(count) > SLOT_LIMIT) ? SLOT_LIMIT : int'(count);
    endfunction

    // a random low slot that is currently taken, or -1
    function int pick_used_slot(int n);
      int lim;
      int s;
      lim = (n < 256) ? n : 256;
      repeat (16) begin
        s = $urandom_range(lim - 1, 0);
        if (in_use[s]) return s;
      end
      return -1;
    endfunction

    function void note_request(logic op, logic [bia_pkg::ID_W-1:0] rid);
      alloc_result_t r;
      int n;
      int slot;
      n     = active_slots();
      r.gid = '0;
      if (op == bia_pkg::OP_ALLOC) begin
        r.st = bia_pkg::ST_NONE_FREE;
        for (int i = 0; i < n; i++) begin
          if (!in_use[i]) begin
            in_use[i] = 1'b1;
            r.gid     = bia_pkg::GRANT_W'(int'(base) + i);
            r.st      = bia_pkg::ST_OK;
            break;
          end
        end
      end else if (int'(rid) < int'(base) || int'(rid) - int'(base) >= n) begin
        r.st = bia_pkg::ST_RANGE;
      end else begin
        slot = int'(rid) - int'(base);
        if (!in_use[slot]) begin
          r.st = bia_pkg::ST_NOT_USED;
        end else begin
          in_use[slot] = 1'b0;
          r.st         = bia_pkg::ST_OK;
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [bia_pkg::GRANT_W-1:0] gid);
      alloc_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word status=%0d granted_id=%0d", $time, st, gid);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
      if (gid !== e.gid) begin
        $display("%0t: granted_id expected %0d actual %0d", $time, e.gid, gid);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           psel, penable, pwrite;
  logic [bia_pkg::PADDR_W-1:0]    paddr;
  logic [bia_pkg::PDATA_W-1:0]    pwdata;
  logic [bia_pkg::PDATA_W-1:0]    prdata;
  logic                           pready;
  logic                           in_valid, in_ready;
  logic                           operation;
  logic [bia_pkg::ID_W-1:0]       id;
  logic                           out_valid, out_ready;
  logic [1:0]                     status;
  logic [bia_pkg::GRANT_W-1:0]    granted_id;

  alloc_scoreboard sb = new();
  bit send_idle;
  bit recv_idle;
  bit hold_output;
  int cycles;

  bitmap_id_allocator_core #(
    .SLOT_LIMIT(SLOT_LIMIT)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .id         (id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .granted_id (granted_id)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result word monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(status, granted_id);
  end

  // receiver: random stalls, plus one long hold-off when asked
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = recv_idle ? $urandom_range(19, 0) : 0;
      if (hold_output) begin
        gap         = 400;
        hold_output = 1'b0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // register write over apb, to be called from clock-aligned code
  task automatic write_reg(logic idx, logic [bia_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bia_pkg::PADDR_W'(idx) << 2;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bia_pkg::REG_BASE) sb.base = data[bia_pkg::ID_W-1:0];
    else                          sb.count = data[bia_pkg::CNT_W-1:0];
  endtask

  // upper data bits carry junk the register must drop
  task automatic set_pool(logic [bia_pkg::ID_W-1:0] b, logic [bia_pkg::CNT_W-1:0] n);
    write_reg(bia_pkg::REG_BASE, ($urandom & 32'hFFFF_0000) | 32'(b));
    write_reg(bia_pkg::REG_COUNT, ($urandom & 32'hFFFF_C000) | 32'(n));
  endtask

  // offer one request word and return at the edge it is taken
  task automatic send(logic op, logic [bia_pkg::ID_W-1:0] v);
    int gap;
    gap = send_idle ? $urandom_range(19, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    id        <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, v);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly well-formed traffic: allocations and releases of taken slots
  task automatic random_request();
    int n;
    int r;
    int s;
    logic op;
    logic [bia_pkg::ID_W-1:0] v;
    n  = sb.active_slots();
    r  = $urandom_range(99, 0);
    op = bia_pkg::OP_RELEASE;
    v  = bia_pkg::ID_W'($urandom);
    if (r < 45) begin
      op = bia_pkg::OP_ALLOC;
    end else if (r < 80 && n > 0) begin
      s = sb.pick_used_slot(n);
      if (s < 0) s = $urandom_range(n - 1, 0);
      v = bia_pkg::ID_W'(int'(sb.base) + s);
    end else if (r < 90 && n > 0) begin
      v = bia_pkg::ID_W'(int'(sb.base) + $urandom_range(n - 1, 0));
    end
    send(op, v);
  endtask

  task automatic random_setting(int p);
    int r;
    logic [bia_pkg::ID_W-1:0]  b;
    logic [bia_pkg::CNT_W-1:0] n;
    r = $urandom_range(99, 0);
    b = bia_pkg::ID_W'($urandom);
    if (r < 30)      n = bia_pkg::CNT_W'($urandom_range(16, 1));
    else if (r < 60) n = bia_pkg::CNT_W'($urandom_range(300, 17));
    else if (r < 70) n = bia_pkg::CNT_W'($urandom_range(8191, 301));
    else if (r < 80) n = bia_pkg::CNT_W'(SLOT_LIMIT);
    else if (r < 92) n = bia_pkg::CNT_W'($urandom_range(16383, SLOT_LIMIT + 1));
    else             n = '0;
    case (p)
      0: begin b = '0;      n = bia_pkg::CNT_W'(SLOT_LIMIT); end
      1: begin b = 16'hFFFF; n = 14'd200;                   end
      2: n = 14'h3FFF;
      default: ;
    endcase
    set_pool(b, n);
  endtask

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    operation = bia_pkg::OP_ALLOC;
    id        = '0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_output = 1'b0;
    cycles    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset range: edges of the range, empty pool, reuse of a freed slot
    send(bia_pkg::OP_RELEASE, 16'd300);
    send(bia_pkg::OP_RELEASE, 16'd299);
    send(bia_pkg::OP_RELEASE, 16'd5001);
    send(bia_pkg::OP_RELEASE, 16'd5000);
    send(bia_pkg::OP_RELEASE, 16'h0000);
    send(bia_pkg::OP_RELEASE, 16'hFFFF);
    send(bia_pkg::OP_ALLOC, 16'hFFFF);
    send(bia_pkg::OP_ALLOC, 16'h0000);
    send(bia_pkg::OP_ALLOC, 16'h5A5A);
    send(bia_pkg::OP_RELEASE, 16'd301);
    send(bia_pkg::OP_RELEASE, 16'd301);
    send(bia_pkg::OP_ALLOC, 16'hA5A5);
    wait_idle();

    // single slot pool, taken over from the earlier base
    set_pool(16'd0, 14'd1);
    send(bia_pkg::OP_ALLOC, 16'd0);
    send(bia_pkg::OP_RELEASE, 16'd0);
    send(bia_pkg::OP_ALLOC, 16'd0);
    send(bia_pkg::OP_ALLOC, 16'd0);
    send(bia_pkg::OP_RELEASE, 16'd1);
    wait_idle();

    // zero slot count
    write_reg(bia_pkg::REG_COUNT, 32'd0);
    send(bia_pkg::OP_ALLOC, 16'd0);
    send(bia_pkg::OP_RELEASE, 16'd0);
    wait_idle();

    // top base with a count above the slot limit
    set_pool(16'hFFFF, 14'h3FFF);
    send(bia_pkg::OP_ALLOC, 16'd0);
    send(bia_pkg::OP_RELEASE, 16'hFFFF);
    send(bia_pkg::OP_ALLOC, 16'd0);
    send(bia_pkg::OP_RELEASE, 16'd0);
    wait_idle();

    // random phases under varied settings and idling
    for (int p = 0; p < PHASES; p++) begin
      random_setting(p);
      send_idle = ($urandom_range(3, 0) != 0);
      recv_idle = ($urandom_range(3, 0) != 0);
      if (p == 3 || p == 7) begin
        send_idle   = 1'b0;
        hold_output = 1'b1;
      end
      repeat (PHASE_WORDS) random_request();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
